[rtl/wsfr_pkg.sv]
// Types and constants shared by the frame receiver modules.
// No dependencies.

package wsfr_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_SIZE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ALLOW_UNMASKED = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CLIENT_ROLE    = 2'd2;

	localparam logic [31:0] MAX_SIZE_RST = 32'd33554432;

	localparam logic [3:0] OPC_CONT  = 4'h0;
	localparam logic [3:0] OPC_BIN   = 4'h2;
	localparam logic [3:0] OPC_CLOSE = 4'h8;
	localparam logic [3:0] OPC_PING  = 4'h9;

	localparam logic [6:0] LEN_EXT16 = 7'd126;
	localparam logic [6:0] LEN_EXT64 = 7'd127;

	typedef enum logic [2:0] {
		PH_B1  = 3'd0,
		PH_B2  = 3'd1,
		PH_LEN = 3'd2,
		PH_KEY = 3'd3,
		PH_PAY = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		EV_DATA        = 3'd0,
		EV_EMPTY       = 3'd1,
		EV_PONG        = 3'd2,
		EV_CLOSE_OK    = 3'd3,
		EV_CLOSE_PROTO = 3'd4,
		EV_TOO_LONG    = 3'd5
	} ev_t;

	typedef struct packed {
		logic [31:0] size_limit;
		logic        allow_unmasked;
		logic        client_role;
	} cfg_t;

	typedef struct packed {
		logic       valid;
		ev_t        kind;
		logic [7:0] data;
		logic [3:0] opc;
		logic       last;
	} evt_t;

endpackage

[rtl/wsfr_if.sv]
// Handshake channel interfaces: received bytes in, events out.
// Depends on nothing.

interface wsfr_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface wsfr_evt_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_kind;
	logic [7:0] data_byte;
	logic [3:0] message_opcode;
	logic       message_last;

	modport source(output valid, output event_kind, output data_byte,
		output message_opcode, output message_last, input ready);
	modport sink(input valid, input event_kind, input data_byte,
		input message_opcode, input message_last, output ready);
endinterface

[rtl/wsfr_parser.sv]
// Frame header parser and payload unmasker; one byte per step.
// Depends on wsfr_pkg.

module wsfr_parser import wsfr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] rx_byte,
	input  cfg_t       cfg,
	output evt_t       evt
);

	phase_t      phase_q, phase_n;
	logic        final_q, final_n;
	logic [3:0]  fopc_q, fopc_n;
	logic        masked_q, masked_n;
	logic [63:0] left_q, left_n;
	logic [3:0]  hdr_q, hdr_n;
	logic [31:0] key_q, key_n;
	logic [1:0]  pos_q, pos_n;
	logic [3:0]  mopc_q, mopc_n;
	logic [31:0] mlen_q, mlen_n;
	logic        closed_q, closed_n;

	logic        do_len, do_start, do_end;
	logic        is_data, data_ok, too_long;
	logic [32:0] len_sum;
	logic [31:0] key_sh;
	logic [7:0]  plain;

	always_comb begin
		phase_n  = phase_q;
		final_n  = final_q;
		fopc_n   = fopc_q;
		masked_n = masked_q;
		left_n   = left_q;
		hdr_n    = hdr_q;
		key_n    = key_q;
		pos_n    = pos_q;
		mopc_n   = mopc_q;
		mlen_n   = mlen_q;
		closed_n = closed_q;
		evt      = '0;
		do_len   = 1'b0;
		do_start = 1'b0;
		do_end   = 1'b0;
		too_long = 1'b0;
		len_sum  = '0;
		key_sh   = key_q << {pos_q, 3'b000};
		plain    = rx_byte ^ (masked_q ? key_sh[31:24] : 8'h00);

		if (!closed_q) begin
			case (phase_q)
				PH_B1: begin
					final_n = rx_byte[7];
					fopc_n  = rx_byte[3:0];
					phase_n = PH_B2;
				end
				PH_B2: begin
					masked_n = rx_byte[7];
					if (rx_byte[6:0] == LEN_EXT16 || rx_byte[6:0] == LEN_EXT64) begin
						left_n  = '0;
						hdr_n   = (rx_byte[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
						phase_n = PH_LEN;
					end else begin
						left_n = {57'd0, rx_byte[6:0]};
						do_len = 1'b1;
					end
				end
				PH_LEN: begin
					left_n = {left_q[55:0], rx_byte};
					hdr_n  = hdr_q - 4'd1;
					do_len = (hdr_q == 4'd1);
				end
				PH_KEY: begin
					key_n    = {key_q[23:0], rx_byte};
					hdr_n    = hdr_q - 4'd1;
					do_start = (hdr_q == 4'd1);
				end
				PH_PAY: begin
					pos_n = pos_q + 2'd1;
					if (left_q != '0)
						left_n = left_q - 64'd1;
					is_data = (fopc_q <= OPC_BIN);
					data_ok = is_data && (cfg.client_role || masked_q || cfg.allow_unmasked);
					if (data_ok) begin
						evt.valid = 1'b1;
						evt.kind  = EV_DATA;
						evt.data  = plain;
						evt.opc   = mopc_q;
						evt.last  = (left_n == '0) && final_q;
						if (left_n == '0) begin
							phase_n = PH_B1;
							if (final_q) begin
								mopc_n = '0;
								mlen_n = '0;
							end
						end
					end else begin
						do_end = (left_n == '0);
					end
				end
				default: phase_n = PH_B1;
			endcase

			// size check as soon as the length is known, control frames too
			if (do_len) begin
				len_sum  = {1'b0, mlen_q} + {1'b0, left_n[31:0]};
				too_long = (left_n[63:32] != '0) || (len_sum >= {1'b0, cfg.size_limit});
				if (too_long) begin
					closed_n  = 1'b1;
					evt.valid = 1'b1;
					evt.kind  = EV_TOO_LONG;
				end else if (masked_n) begin
					phase_n = PH_KEY;
					hdr_n   = 4'd4;
					key_n   = '0;
				end else begin
					do_start = 1'b1;
				end
			end

			is_data = (fopc_n <= OPC_BIN);
			data_ok = is_data && (cfg.client_role || masked_n || cfg.allow_unmasked);

			if (do_start) begin
				pos_n = '0;
				if (data_ok) begin
					if (mopc_n == OPC_CONT && fopc_n != OPC_CONT)
						mopc_n = fopc_n;
					mlen_n = mlen_q + left_n[31:0];
				end
				if (left_n == '0)
					do_end = 1'b1;
				else
					phase_n = PH_PAY;
			end

			if (do_end) begin
				phase_n = PH_B1;
				if (fopc_n == OPC_PING) begin
					evt.valid = 1'b1;
					evt.kind  = EV_PONG;
				end else if (fopc_n == OPC_CLOSE) begin
					closed_n  = 1'b1;
					evt.valid = 1'b1;
					evt.kind  = EV_CLOSE_OK;
				end else if (is_data && !data_ok) begin
					closed_n  = 1'b1;
					evt.valid = 1'b1;
					evt.kind  = EV_CLOSE_PROTO;
				end else if (is_data && final_n) begin
					evt.valid = 1'b1;
					evt.kind  = EV_EMPTY;
					evt.opc   = mopc_n;
					evt.last  = 1'b1;
					mopc_n    = '0;
					mlen_n    = '0;
				end
			end
		end else begin
			is_data = 1'b0;
			data_ok = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_B1;
			final_q  <= 1'b0;
			fopc_q   <= '0;
			masked_q <= 1'b0;
			left_q   <= '0;
			hdr_q    <= '0;
			key_q    <= '0;
			pos_q    <= '0;
			mopc_q   <= '0;
			mlen_q   <= '0;
			closed_q <= 1'b0;
		end else if (step) begin
			phase_q  <= phase_n;
			final_q  <= final_n;
			fopc_q   <= fopc_n;
			masked_q <= masked_n;
			left_q   <= left_n;
			hdr_q    <= hdr_n;
			key_q    <= key_n;
			pos_q    <= pos_n;
			mopc_q   <= mopc_n;
			mlen_q   <= mlen_n;
			closed_q <= closed_n;
		end
	end

endmodule

[rtl/wsfr_out_reg.sv]
// Result register between the parser and the event channel.
// Depends on wsfr_pkg and wsfr_if.

module wsfr_out_reg import wsfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  evt_t        evt,
	output logic        free,
	wsfr_evt_if.source  out_ch
);

	logic valid_q;
	evt_t evt_q;

	assign free = !valid_q || out_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= evt.valid;
		end else if (out_ch.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && evt.valid)
			evt_q <= evt;
	end

	assign out_ch.valid          = valid_q;
	assign out_ch.event_kind     = evt_q.kind;
	assign out_ch.data_byte      = evt_q.data;
	assign out_ch.message_opcode = evt_q.opc;
	assign out_ch.message_last   = evt_q.last;

endmodule

[rtl/websocket_frame_receiver_top.sv]
// Top level of the frame receiver: input register, config registers,
// parser and result register. Depends on wsfr_pkg, wsfr_if, wsfr_parser, wsfr_out_reg.
//
//   channel   dir   payload                                               width
//   in_ch     in    rx_byte                                               8
//   out_ch    out   event_kind, data_byte, message_opcode, message_last   3+8+4+1
//   cfg       in    cfg_wr_en, cfg_index, cfg_wdata                       1+2+32
//
// One byte per cycle while the result register is free; a transferred byte passes the
// input register, then the parser into the result register, before its event shows.
// arst_n clears parser state and loads the register reset values; no clearing pass.
// A held event stalls the parser; the input register still takes one more byte.
// After a close or a drop every byte is taken and dropped until reset.

module websocket_frame_receiver_top import wsfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	wsfr_byte_if.sink             in_ch,
	wsfr_evt_if.source            out_ch
);

	cfg_t       cfg_q;
	logic       in_valid_s1;
	logic [7:0] in_byte_s1;
	logic       out_free;
	logic       step;
	evt_t       evt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.size_limit     <= MAX_SIZE_RST;
			cfg_q.allow_unmasked <= 1'b0;
			cfg_q.client_role    <= 1'b0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAX_SIZE:       cfg_q.size_limit     <= cfg_wdata;
				REG_ALLOW_UNMASKED: cfg_q.allow_unmasked <= cfg_wdata[0];
				REG_CLIENT_ROLE:    cfg_q.client_role    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	assign step        = in_valid_s1 && out_free;
	assign in_ch.ready = !in_valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			in_valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid)
			in_byte_s1 <= in_ch.rx_byte;
	end

	wsfr_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.rx_byte (in_byte_s1),
		.cfg     (cfg_q),
		.evt     (evt)
	);

	wsfr_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (step),
		.evt    (evt),
		.free   (out_free),
		.out_ch (out_ch)
	);

endmodule

[dv/wsfr_checker.sv]
// Scoreboard for the frame receiver: follows register writes and byte transfers,
// predicts each event and compares it with the event channel.
// Depends on wsfr_pkg.

module wsfr_checker import wsfr_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [7:0]            in_byte,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [2:0]            out_kind,
	input  logic [7:0]            out_data,
	input  logic [3:0]            out_opc,
	input  logic                  out_last,
	output int unsigned           mismatches,
	output int unsigned           outstanding,
	output int unsigned           events_checked,
	output logic [5:0]            kinds_seen
);

	typedef struct {
		ev_t        kind;
		logic [7:0] data;
		logic [3:0] opc;
		logic       last;
	} event_rec_t;

	event_rec_t pending_events[$];

	cfg_t        regs;
	phase_t      ph;
	logic        fin;
	logic [3:0]  fopc;
	logic        masked;
	logic [63:0] left;
	logic [3:0]  hdr_left;
	logic [31:0] key;
	logic [1:0]  key_pos;
	logic [3:0]  m_opc;
	logic [31:0] m_len;
	logic        dead;

	int unsigned err_cnt;
	int unsigned chk_cnt;
	logic [5:0]  seen;
	logic        hit;
	event_rec_t  got_ev;
	event_rec_t  want;

	function automatic event_rec_t mk_event(ev_t k, logic [7:0] d, logic [3:0] o, logic l);
		mk_event = '{kind: k, data: d, opc: o, last: l};
	endfunction

	function automatic logic is_data();
		return fopc <= OPC_BIN;
	endfunction

	// data frame without a mask in strict server mode
	function automatic logic refused();
		return is_data() && !regs.client_role && !masked && !regs.allow_unmasked;
	endfunction

	task automatic frame_done(output logic h, output event_rec_t ev);
		ph = PH_B1;
		h = 1'b1;
		ev = mk_event(EV_DATA, 8'd0, 4'd0, 1'b0);
		if (fopc == OPC_PING) begin
			ev = mk_event(EV_PONG, 8'd0, 4'd0, 1'b0);
		end else if (fopc == OPC_CLOSE) begin
			dead = 1'b1;
			ev = mk_event(EV_CLOSE_OK, 8'd0, 4'd0, 1'b0);
		end else if (refused()) begin
			dead = 1'b1;
			ev = mk_event(EV_CLOSE_PROTO, 8'd0, 4'd0, 1'b0);
		end else if (is_data() && fin) begin
			ev = mk_event(EV_EMPTY, 8'd0, m_opc, 1'b1);
			m_opc = OPC_CONT;
			m_len = 32'd0;
		end else begin
			h = 1'b0;
		end
	endtask

	task automatic payload_begin(output logic h, output event_rec_t ev);
		key_pos = 2'd0;
		h = 1'b0;
		ev = mk_event(EV_DATA, 8'd0, 4'd0, 1'b0);
		if (is_data() && !refused()) begin
			if (m_opc == OPC_CONT && fopc != OPC_CONT)
				m_opc = fopc;
			m_len = m_len + left[31:0];
		end
		if (left == 64'd0)
			frame_done(h, ev);
		else
			ph = PH_PAY;
	endtask

	// size limit applies as soon as the length is known, any opcode
	task automatic length_check(output logic h, output event_rec_t ev);
		logic [63:0] lim;
		logic [63:0] total;
		lim = {32'd0, regs.size_limit};
		total = {32'd0, m_len} + left;
		h = 1'b0;
		ev = mk_event(EV_DATA, 8'd0, 4'd0, 1'b0);
		if (left >= lim || total >= lim) begin
			dead = 1'b1;
			h = 1'b1;
			ev = mk_event(EV_TOO_LONG, 8'd0, 4'd0, 1'b0);
		end else if (masked) begin
			ph = PH_KEY;
			hdr_left = 4'd4;
			key = 32'd0;
		end else begin
			payload_begin(h, ev);
		end
	endtask

	task automatic parse_rx_byte(input logic [7:0] b, output logic h, output event_rec_t ev);
		logic [7:0] kb;
		h = 1'b0;
		ev = mk_event(EV_DATA, 8'd0, 4'd0, 1'b0);
		if (!dead) begin
			case (ph)
				PH_B1: begin
					fin = b[7];
					fopc = b[3:0];
					ph = PH_B2;
				end
				PH_B2: begin
					masked = b[7];
					left = 64'd0;
					if (b[6:0] == LEN_EXT16 || b[6:0] == LEN_EXT64) begin
						hdr_left = (b[6:0] == LEN_EXT16) ? 4'd2 : 4'd8;
						ph = PH_LEN;
					end else begin
						left = {57'd0, b[6:0]};
						length_check(h, ev);
					end
				end
				PH_LEN: begin
					left = {left[55:0], b};
					hdr_left = hdr_left - 4'd1;
					if (hdr_left == 4'd0)
						length_check(h, ev);
				end
				PH_KEY: begin
					key = {key[23:0], b};
					hdr_left = hdr_left - 4'd1;
					if (hdr_left == 4'd0)
						payload_begin(h, ev);
				end
				PH_PAY: begin
					kb = masked ? key[8 * (3 - int'(key_pos)) +: 8] : 8'd0;
					key_pos = key_pos + 2'd1;
					if (left != 64'd0)
						left = left - 64'd1;
					if (is_data() && !refused()) begin
						h = 1'b1;
						ev = mk_event(EV_DATA, b ^ kb, m_opc, left == 64'd0 && fin);
						if (left == 64'd0) begin
							ph = PH_B1;
							if (fin) begin
								m_opc = OPC_CONT;
								m_len = 32'd0;
							end
						end
					end else if (left == 64'd0) begin
						frame_done(h, ev);
					end
				end
				default: ph = PH_B1;
			endcase
		end
	endtask

	function automatic int field_check(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs = '{size_limit: MAX_SIZE_RST, allow_unmasked: 1'b0, client_role: 1'b0};
			ph = PH_B1;
			fin = 1'b0;
			fopc = 4'd0;
			masked = 1'b0;
			left = 64'd0;
			hdr_left = 4'd0;
			key = 32'd0;
			key_pos = 2'd0;
			m_opc = 4'd0;
			m_len = 32'd0;
			dead = 1'b0;
			err_cnt = 0;
			chk_cnt = 0;
			seen = '0;
			pending_events.delete();
			mismatches <= 0;
			outstanding <= 0;
			events_checked <= 0;
			kinds_seen <= '0;
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MAX_SIZE:       regs.size_limit = cfg_wdata;
					REG_ALLOW_UNMASKED: regs.allow_unmasked = cfg_wdata[0];
					REG_CLIENT_ROLE:    regs.client_role = cfg_wdata[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				parse_rx_byte(in_byte, hit, got_ev);
				if (hit)
					pending_events.push_back(got_ev);
			end
			if (out_valid && out_ready) begin
				if (pending_events.size() == 0) begin
					$error("event with nothing expected: event_kind %0d", out_kind);
					err_cnt++;
				end else begin
					want = pending_events.pop_front();
					err_cnt += field_check("event_kind", 8'(want.kind), 8'(out_kind));
					err_cnt += field_check("data_byte", want.data, out_data);
					err_cnt += field_check("message_opcode", 8'(want.opc), 8'(out_opc));
					err_cnt += field_check("message_last", 8'(want.last), 8'(out_last));
					chk_cnt++;
				end
				if (out_kind <= EV_TOO_LONG)
					seen[out_kind] = 1'b1;
			end
			mismatches <= err_cnt;
			outstanding <= pending_events.size();
			events_checked <= chk_cnt;
			kinds_seen <= seen;
		end
	end

endmodule

[dv/tb_top.sv]
// Testbench top for websocket_frame_receiver_top: clock, reset, frame stimulus,
// register settings, output back-pressure and the verdict.
// Depends on wsfr_pkg, wsfr_if, wsfr_checker and the receiver RTL.

module tb_top import wsfr_pkg::*; ();

	localparam logic [3:0]           OPC_TEXT   = 4'h1;
	localparam logic [3:0]           OPC_PONG   = 4'hA;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int                   HOLD_CYCLES = 64;

	typedef enum int {LEN_7, LEN_16, LEN_64} len_form_t;
	typedef enum int {END_CLOSE, END_UNMASKED, END_TOO_LONG} link_end_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	wsfr_byte_if in_ch();
	wsfr_evt_if  out_ch();

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned events_checked;
	logic [5:0]  kinds_seen;

	// sender-side view of the link, used to keep frames legal
	longint unsigned max_sz;
	longint unsigned msg_len;
	logic            msg_open;
	logic            unmasked_ok;
	int unsigned     n_sent;
	int unsigned     n_settings;
	logic            idle_en;
	logic            hold_req;
	logic            hold_done;

	websocket_frame_receiver_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	wsfr_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_ch.valid),
		.in_ready      (in_ch.ready),
		.in_byte       (in_ch.rx_byte),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_kind      (out_ch.event_kind),
		.out_data      (out_ch.data_byte),
		.out_opc       (out_ch.message_opcode),
		.out_last      (out_ch.message_last),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.events_checked(events_checked),
		.kinds_seen    (kinds_seen)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#1600000;
		$display("tb_top failed");
		$finish;
	end

	// event sink: random stalls, plus one long hold-off on request
	initial begin
		hold_done = 1'b0;
		forever begin
			if (hold_req && !hold_done) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_done = 1'b1;
			end else if (idle_en && $urandom_range(0, 5) == 0) begin
				out_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
			end else begin
				out_ch.ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	task automatic send_byte(input logic [7:0] b);
		if (idle_en && $urandom_range(0, 4) == 0) begin
			in_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.rx_byte <= b;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		n_sent++;
	endtask

	function automatic longint unsigned len_room();
		if (msg_len + 1 > max_sz)
			return 0;
		return max_sz - 1 - msg_len;
	endfunction

	task automatic send_frame(input logic fin, input logic [3:0] opc, input logic masked,
			input longint unsigned len, input len_form_t form);
		logic [31:0] key;
		logic [63:0] len_bits;
		len_bits = len;
		key = $urandom;
		// RSV bits are ignored by the parser, so they get random values
		send_byte({fin, 3'($urandom_range(0, 7)), opc});
		case (form)
			LEN_7: send_byte({masked, len_bits[6:0]});
			LEN_16: begin
				send_byte({masked, LEN_EXT16});
				send_byte(len_bits[15:8]);
				send_byte(len_bits[7:0]);
			end
			default: begin
				send_byte({masked, LEN_EXT64});
				for (int k = 7; k >= 0; k--)
					send_byte(len_bits[8 * k +: 8]);
			end
		endcase
		if (masked)
			for (int k = 3; k >= 0; k--)
				send_byte(key[8 * k +: 8]);
		for (longint unsigned i = 0; i < len; i++)
			send_byte(8'($urandom));
		if (opc <= OPC_BIN) begin
			if (fin) begin
				msg_len = 0;
				msg_open = 1'b0;
			end else begin
				msg_len += len;
				msg_open = 1'b1;
			end
		end
	endtask

	task automatic gen_frame();
		int pick;
		int r;
		logic [3:0] opc;
		logic fin;
		logic masked;
		longint unsigned len;
		len_form_t form;
		pick = $urandom_range(0, 99);
		if (pick < 62) begin
			if (msg_open)
				opc = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? OPC_TEXT : OPC_BIN)
					: OPC_CONT;
			else
				opc = ($urandom_range(0, 9) == 0) ? OPC_CONT
					: ($urandom_range(0, 1) ? OPC_TEXT : OPC_BIN);
			fin = 1'($urandom_range(0, 1));
		end else begin
			if (pick < 78) begin
				opc = OPC_PING;
			end else if (pick < 88) begin
				opc = OPC_PONG;
			end else begin
				// reserved opcodes 3..7 and 11..15
				r = $urandom_range(0, 9);
				opc = (r < 5) ? 4'(3 + r) : 4'(6 + r);
			end
			fin = ($urandom_range(0, 3) != 0);
		end
		masked = (opc <= OPC_BIN && !unmasked_ok) ? 1'b1 : 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 70) begin
			len = 64'($urandom_range(0, 10));
			form = LEN_7;
		end else if (r < 90) begin
			len = 64'($urandom_range(11, 60));
			form = LEN_7;
		end else if (r < 98) begin
			len = 64'($urandom_range(0, 180));
			form = LEN_16;
		end else begin
			len = 64'($urandom_range(0, 40));
			form = LEN_64;
		end
		if (len > len_room())
			len = len_room();
		send_frame(fin, opc, masked, len, form);
	endtask

	task automatic configure(input logic [31:0] size_limit, input logic au, input logic cr);
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MAX_SIZE;
		cfg_wdata <= size_limit;
		@(posedge clk);
		cfg_index <= REG_ALLOW_UNMASKED;
		cfg_wdata <= {31'd0, au};
		@(posedge clk);
		cfg_index <= REG_CLIENT_ROLE;
		cfg_wdata <= {31'd0, cr};
		@(posedge clk);
		// write to an unmapped index must change nothing
		cfg_index <= REG_UNUSED;
		cfg_wdata <= $urandom;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		max_sz = 64'(size_limit);
		unmasked_ok = au | cr;
		n_settings++;
	endtask

	// wait for all events, then let the pipeline drain bytes that cause none
	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic run_phase(input int unsigned budget);
		int unsigned start;
		start = n_sent;
		while (n_sent - start < budget)
			gen_frame();
		if (msg_open)
			send_frame(1'b1, OPC_CONT, !unmasked_ok, 0, LEN_7);
		settle();
	endtask

	initial begin
		link_end_t   how;
		logic        drain_fail;
		int unsigned fails;
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_MAX_SIZE;
		cfg_wdata <= '0;
		in_ch.valid <= 1'b0;
		in_ch.rx_byte <= 8'd0;
		max_sz = 64'(MAX_SIZE_RST);
		msg_len = 0;
		msg_open = 1'b0;
		unmasked_ok = 1'b0;
		n_sent = 0;
		n_settings = 0;
		idle_en = 1'b1;
		hold_req = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames, client role so most need no key
		configure(32'hFFFF_FFFF, 1'b0, 1'b1);
		send_byte(8'h81); send_byte(8'h00);                    // empty final text
		send_byte(8'h02); send_byte(8'h02);                    // binary, not final
		send_byte(8'h00); send_byte(8'hFF);
		send_byte(8'h80); send_byte(8'h81);                    // masked final continuation
		send_byte(8'hA5); send_byte(8'h5A); send_byte(8'hC3); send_byte(8'h3C);
		send_byte(8'h7E);
		send_byte(8'h89); send_byte(8'h00);                    // ping
		send_byte(8'h8A); send_byte(8'h01); send_byte(8'h33);  // pong, skipped
		send_byte(8'h8B); send_byte(8'h00);                    // reserved opcode
		send_byte(8'h00); send_byte(8'h7E);                    // continuation with no message
		send_byte(8'h00); send_byte(8'h01); send_byte(8'h5A);
		send_byte(8'h80); send_byte(8'h00);                    // empty end of that message
		settle();

		configure(MAX_SIZE_RST, 1'b0, 1'b0);
		hold_req = 1'b1;
		run_phase(400);
		configure(32'd1, 1'b1, 1'b0);
		run_phase(150);
		configure(32'($urandom_range(20, 60)), 1'b1, 1'b0);
		run_phase(300);
		configure(32'hFFFF_FFFF, 1'b0, 1'b1);
		run_phase(400);
		configure(32'($urandom_range(200, 5000)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
		run_phase(400);
		idle_en = 1'b0;
		configure(32'hFFFF_FFFF, 1'b1, 1'b1);
		run_phase(250);

		// one way of ending the link per run; later bytes must be dropped
		how = link_end_t'($urandom_range(0, 2));
		case (how)
			END_CLOSE: send_frame(1'b1, OPC_CLOSE, 1'($urandom_range(0, 1)), 2, LEN_7);
			END_UNMASKED: begin
				configure(32'hFFFF_FFFF, 1'b0, 1'b0);
				send_frame(1'b1, OPC_TEXT, 1'b0, 3, LEN_7);
			end
			default: begin
				send_byte({1'b1, 3'd0, OPC_BIN});
				send_byte({1'b0, LEN_EXT64});
				send_byte({1'b1, 7'($urandom)});
				repeat (7) send_byte(8'($urandom));
			end
		endcase
		repeat (12) send_byte(8'($urandom));

		in_ch.valid <= 1'b0;
		@(posedge clk);
		for (int c = 0; c < 5000 && outstanding != 0; c++)
			@(posedge clk);
		repeat (8) @(posedge clk);
		drain_fail = (outstanding != 0);
		if (drain_fail)
			$error("%0d events never arrived", outstanding);
		fails = mismatches + (drain_fail ? 1 : 0);

		$display("run covered %0d bytes under %0d register settings, %0d events checked, kinds seen %b",
			n_sent, n_settings, events_checked, kinds_seen);
		$display("link ended by %s, then ignored bytes", how.name());
		if (fails == 0)
			$display("tb_top passed");
		else
			$display("tb_top failed");
		$finish;
	end

endmodule
